FILE: rtl/c12pc_pkg.sv
// Shared types, register map and constants for the 12-bit color converter.
package c12pc_pkg;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_BRIGHTNESS      = 3'd0,
    REG_CONTRAST        = 3'd1,
    REG_BYTES_PER_PIXEL = 3'd2,
    REG_USE_555         = 3'd3,
    REG_BLUE_HIGH_SHIFT = 3'd4
  } reg_idx_t;

  // Output format codes; anything else packs as plain RGB
  localparam logic [2:0] FMT_16BIT = 3'd2;
  localparam logic [2:0] FMT_24BIT = 3'd3;
  localparam logic [2:0] FMT_RESET = 3'd4;

  localparam int unsigned LEVEL_W = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  // Live configuration as seen by the datapath
  typedef struct packed {
    logic signed [8:0] brightness;
    logic signed [8:0] contrast;
    logic [2:0]        bytes_per_pixel;
    logic              use_555;
    logic              blue_high_shift;
  } cfg_t;

endpackage

FILE: rtl/c12pc_cfg_regs.sv
// APB-style configuration register file.
module c12pc_cfg_regs import c12pc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness      <= '0;
      cfg.contrast        <= '0;
      cfg.bytes_per_pixel <= FMT_RESET;
      cfg.use_555         <= 1'b0;
      cfg.blue_high_shift <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_BRIGHTNESS:      cfg.brightness      <= pwdata[8:0];
        REG_CONTRAST:        cfg.contrast        <= pwdata[8:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= pwdata[2:0];
        REG_USE_555:         cfg.use_555         <= pwdata[0];
        REG_BLUE_HIGH_SHIFT: cfg.blue_high_shift <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux; signed registers come back sign-extended
  always_comb begin
    case (idx)
      REG_BRIGHTNESS:      prdata = 32'(cfg.brightness);
      REG_CONTRAST:        prdata = 32'(cfg.contrast);
      REG_BYTES_PER_PIXEL: prdata = {29'd0, cfg.bytes_per_pixel};
      REG_USE_555:         prdata = {31'd0, cfg.use_555};
      REG_BLUE_HIGH_SHIFT: prdata = {31'd0, cfg.blue_high_shift};
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: rtl/c12pc_channel.sv
// One color lane: nibble unscramble, contrast gain, brightness offset, clamp.
module c12pc_channel import c12pc_pkg::*; (
  input  logic [3:0]         nib,
  input  cfg_t               cfg,
  output logic [LEVEL_W-1:0] level
);

  logic [7:0]         lvl;
  logic [8:0]         gain;
  logic [16:0]        prod;
  logic signed [10:0] sum;

  // Low nibble bits become level bits 7..5, top bit becomes bit 4
  assign lvl  = {nib[2:0], nib[3], 4'b0000};
  // contrast + 256 over a 9-bit signed value is a flip of its sign bit
  assign gain = {~cfg.contrast[8], cfg.contrast[7:0]};
  assign prod = 17'(lvl) * 17'(gain);
  assign sum  = $signed({2'b00, prod[16:8]}) + 11'(cfg.brightness);

  // Clamp to 0..255
  always_comb begin
    if (sum[10]) begin
      level = '0;
    end else if (sum[9:8] != 2'b00) begin
      level = LEVEL_MAX;
    end else begin
      level = sum[7:0];
    end
  end

endmodule

FILE: rtl/c12pc_pack.sv
// Packs three channel levels into the configured host pixel layout.
module c12pc_pack import c12pc_pkg::*; (
  input  logic [LEVEL_W-1:0] red,
  input  logic [LEVEL_W-1:0] green,
  input  logic [LEVEL_W-1:0] blue,
  input  cfg_t               cfg,
  output logic [31:0]        pixel
);

  logic [15:0] c16;

  // 565 or 555 sixteen-bit word
  always_comb begin
    if (cfg.use_555) begin
      c16 = {1'b0, red[7:3], green[7:3], blue[7:3]};
    end else begin
      c16 = {red[7:3], green[7:2], blue[7:3]};
    end
  end

  always_comb begin
    case (cfg.bytes_per_pixel)
      FMT_16BIT: pixel = {c16, c16};
      FMT_24BIT: pixel = {blue, red, green, blue};
      default: begin
        if (cfg.blue_high_shift) begin
          pixel = {red, green, blue, 8'h00};
        end else begin
          pixel = {8'h00, red, green, blue};
        end
      end
    endcase
  end

endmodule

FILE: rtl/color12_to_pixel_converter.sv
// Top level: 12-bit machine color to host pixel word converter.
//
//   channel   direction  handshake        payload
//   s_*       in         tvalid/tready    tdata[11:0] source_color
//   m_*       out        tvalid/tready    tdata[31:0] pixel_word
//   apb       in         psel/penable     brightness, contrast, format regs
//
// Two register stages: input register, then result register, with the three
// lane multipliers between them. One word per cycle unless the output stalls.
// A stalled output holds its word; an empty input register still takes one.
// Synchronous reset clears valids and loads register defaults (format 4).
module color12_to_pixel_converter import c12pc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input word stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] source_color, [15:12] zero fill
  // output word stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] pixel_word
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t               cfg;
  logic               in_valid;
  logic [11:0]        in_color;
  logic               out_adv;
  logic [LEVEL_W-1:0] red, green, blue;
  logic [31:0]        pixel;

  c12pc_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Handshake: result register frees when empty or taken downstream
  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_color <= s_tdata[11:0];
    end
  end

  // Three channel lanes
  c12pc_channel u_red   (.nib(in_color[11:8]), .cfg, .level(red));
  c12pc_channel u_green (.nib(in_color[7:4]),  .cfg, .level(green));
  c12pc_channel u_blue  (.nib(in_color[3:0]),  .cfg, .level(blue));

  c12pc_pack u_pack (.red, .green, .blue, .cfg, .pixel);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      m_tdata <= pixel;
    end
  end

`ifndef NO_ASSERTIONS
  // An empty input register always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but not ready");

  // An accepted word reaches the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted word lost at input register");

  // A word in the input register moves on when the result register frees
  a_forward: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_adv |=> m_tvalid)
    else $error("word lost between stages");
`endif

endmodule
